/* src/bm3_pkg.sv */
// Shared types and constants for the 3x3 binary morphology unit.
// No dependencies; used by every module of the block.
`default_nettype none
package bm3_pkg;

  localparam int PIX_W         = 8;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int ROW_W        = 13;
  localparam int CMP_W        = 14;

  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd480;
  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;

  typedef struct packed {
    logic             emit;
    logic             interior;
    logic             frame_end;
    logic [PIX_W-1:0] pix;
  } bm3_item_t;

endpackage
`default_nettype wire

/* src/bm3_line_buf.sv */
// Two line stores (upper and middle row), one write and one registered read port.
// Depends on bm3_pkg.
`default_nettype none
module bm3_line_buf #(
  parameter int DEPTH = bm3_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]       rd_addr,
  output logic      [bm3_pkg::PIX_W-1:0]      rd_top,
  output logic      [bm3_pkg::PIX_W-1:0]      rd_mid,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]       wr_addr,
  input  wire logic [bm3_pkg::PIX_W-1:0]      wr_upper,
  input  wire logic [bm3_pkg::PIX_W-1:0]      wr_middle
);

  logic [bm3_pkg::PIX_W-1:0] upper_mem [DEPTH];
  logic [bm3_pkg::PIX_W-1:0] middle_mem [DEPTH];
  logic [bm3_pkg::PIX_W-1:0] rd_top_r;
  logic [bm3_pkg::PIX_W-1:0] rd_mid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
    if (rd_en) begin
      rd_top_r <= upper_mem[rd_addr];
      rd_mid_r <= middle_mem[rd_addr];
    end
  end

  assign rd_top = rd_top_r;
  assign rd_mid = rd_mid_r;

endmodule
`default_nettype wire

/* src/bm3_ctrl.sv */
// Configuration registers, raster position counters and drain bookkeeping.
// Depends on bm3_pkg.
`default_nettype none
module bm3_ctrl #(
  parameter int MAX_WIDTH = bm3_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [bm3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [bm3_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic                                accept,
  input  wire logic [bm3_pkg::PIX_W-1:0]           pixel_in,
  input  wire logic                                flush,
  output logic                                     take,
  output logic      [$clog2(MAX_WIDTH)-1:0]        rd_idx,
  output bm3_pkg::bm3_item_t                       item,
  output logic                                     spread_mode
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int OW = $clog2(MAX_WIDTH + 2);
  localparam int CMPW = bm3_pkg::CMP_W;
  localparam int RW = bm3_pkg::ROW_W;

  logic                               mode_r;
  logic [bm3_pkg::WIDTH_REG_W-1:0]    width_r;
  logic [bm3_pkg::HEIGHT_REG_W-1:0]   height_r;
  logic [CW-1:0]                      col_r, col_nxt;
  logic [RW-1:0]                      row_r, row_nxt;
  logic [OW-1:0]                      owed_r, owed_nxt;

  logic [WW-1:0]   eff_w;
  logic [RW-1:0]   eff_h;
  logic [CMPW-1:0] ci_p1, ri_p1;
  logic            draining, row_end, last_pix, frame_end, emit, interior;

  always_comb begin
    if (CMPW'(width_r) < CMPW'(bm3_pkg::MIN_DIM)) begin
      eff_w = WW'(bm3_pkg::MIN_DIM);
    end else if (CMPW'(width_r) > CMPW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_r);
    end
    if (CMPW'(height_r) < CMPW'(bm3_pkg::MIN_DIM)) begin
      eff_h = RW'(bm3_pkg::MIN_DIM);
    end else if (CMPW'(height_r) > CMPW'(bm3_pkg::MAX_HEIGHT)) begin
      eff_h = RW'(bm3_pkg::MAX_HEIGHT);
    end else begin
      eff_h = RW'(height_r);
    end
  end

  always_comb begin
    draining  = (owed_r != '0);
    take      = accept && (draining || !flush);
    ci_p1     = CMPW'(col_r) + CMPW'(1);
    ri_p1     = CMPW'(row_r) + CMPW'(1);
    row_end   = (ci_p1 >= CMPW'(eff_w));
    emit      = (row_r >= RW'(2)) || ((row_r == RW'(1)) && (col_r != '0));
    interior  = (row_r >= RW'(2)) && (ri_p1 <= CMPW'(eff_h)) &&
                (col_r >= CW'(2)) && (ci_p1 <= CMPW'(eff_w));
    last_pix  = !draining && (ri_p1 >= CMPW'(eff_h)) && row_end;
    frame_end = draining && (owed_r == OW'(1));

    if (row_end) begin
      col_nxt = '0;
      row_nxt = RW'(ri_p1);
    end else begin
      col_nxt = CW'(ci_p1);
      row_nxt = row_r;
    end
    owed_nxt = draining ? owed_r - OW'(1) : owed_r;
    if (frame_end) begin
      col_nxt = '0;
      row_nxt = '0;
    end
    if (last_pix) begin
      owed_nxt = OW'(eff_w) + OW'(1);
    end

    item.emit      = emit;
    item.interior  = interior;
    item.frame_end = frame_end;
    item.pix       = draining ? bm3_pkg::PIX_BLACK : pixel_in;
    rd_idx         = col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      width_r  <= bm3_pkg::WIDTH_RST;
      height_r <= bm3_pkg::HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
      owed_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          bm3_pkg::REG_SPREAD_MODE:  mode_r   <= cfg_wdata[0];
          bm3_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[bm3_pkg::WIDTH_REG_W-1:0];
          bm3_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (take) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        owed_r <= owed_nxt;
      end
    end
  end

  assign spread_mode = mode_r;

endmodule
`default_nettype wire

/* src/bm3_window.sv */
// Item register, 3x3 window, spread filter and result register.
// Depends on bm3_pkg; writes back to bm3_line_buf.
`default_nettype none
module bm3_window #(
  parameter int AW = $clog2(bm3_pkg::MAX_WIDTH_DEF)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           take,
  input  wire bm3_pkg::bm3_item_t             item,
  input  wire logic [AW-1:0]                  idx,
  input  wire logic                           spread_mode,
  input  wire logic [bm3_pkg::PIX_W-1:0]      top,
  input  wire logic [bm3_pkg::PIX_W-1:0]      mid,
  output logic                                stage_free,
  output logic                                wr_en,
  output logic      [AW-1:0]                  wr_addr,
  output logic      [bm3_pkg::PIX_W-1:0]      wr_upper,
  output logic      [bm3_pkg::PIX_W-1:0]      wr_middle,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [bm3_pkg::PIX_W-1:0]      out_pixel_out,
  output logic                                out_frame_last
);

  logic                      s1_valid_r;
  bm3_pkg::bm3_item_t        s1_item_r;
  logic [AW-1:0]             s1_idx_r;
  logic [bm3_pkg::PIX_W-1:0] win_r [9];
  logic [bm3_pkg::PIX_W-1:0] win_nxt [9];
  logic                      out_valid_r;
  logic [bm3_pkg::PIX_W-1:0] out_pix_r;
  logic                      out_last_r;

  logic                      s1_go, hit;
  logic [bm3_pkg::PIX_W-1:0] target, value;

  always_comb begin
    s1_go      = s1_valid_r && (!s1_item_r.emit || !out_valid_r || out_ready);
    stage_free = !s1_valid_r || s1_go;

    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]   = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = top;
    win_nxt[5] = mid;
    win_nxt[8] = s1_item_r.pix;

    target = spread_mode ? bm3_pkg::PIX_WHITE : bm3_pkg::PIX_BLACK;
    hit    = 1'b0;
    for (int k = 0; k < 9; k++) begin
      if (win_nxt[k] == target) begin
        hit = 1'b1;
      end
    end
    value = (s1_item_r.interior && hit) ? target : win_nxt[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      if (take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        for (int k = 0; k < 9; k++) begin
          win_r[k] <= win_nxt[k];
        end
      end
      if (s1_go && s1_item_r.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item_r <= item;
      s1_idx_r  <= idx;
    end
    if (s1_go && s1_item_r.emit) begin
      out_pix_r  <= value;
      out_last_r <= s1_item_r.frame_end;
    end
  end

  assign wr_en          = s1_go;
  assign wr_addr        = s1_idx_r;
  assign wr_upper       = mid;
  assign wr_middle      = s1_item_r.pix;
  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pix_r;
  assign out_frame_last = out_last_r;

endmodule
`default_nettype wire

/* src/binary_morphology_3x3_unit.sv */
// Top level of the streaming 3x3 black/white spread filter.
// Depends on bm3_pkg, bm3_ctrl, bm3_line_buf and bm3_window.
//
// Usage:
//  - Input channel (in_valid/in_ready): one pixel per transfer in raster order.
//    After the frame's last pixel send image_width + 1 transfers with in_flush
//    set; they drain the remaining results. A flush outside a drain is dropped.
//  - Result channel (out_valid/out_ready): one filtered pixel per result, in
//    raster order; out_frame_last marks the frame's last pixel.
//  - Config port: cfg_wr_en writes cfg_wdata to register cfg_index
//    (0 spread_mode, 1 image_width, 2 image_height). Write only while idle.
//  - Throughput: one input transfer per cycle unless a stalled receiver holds
//    the item stage. A pixel's result is released by the transfer image_width
//    + 1 items later and reaches out through the item and result registers.
//  - Reset (rst_n low, synchronous) clears counters, window, pipeline valids
//    and restores width 640, height 480, black spread. Line stores are not
//    cleared; their first reads only reach border pixels.
//  - A stalled receiver holds the result register; the item stage keeps moving
//    for items that give no result and fills once, then in_ready drops.
`default_nettype none
module binary_morphology_3x3_unit #(
  parameter int MAX_WIDTH = bm3_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [bm3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bm3_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [bm3_pkg::PIX_W-1:0]         in_pixel_in,
  input  wire logic                              in_flush,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [bm3_pkg::PIX_W-1:0]         out_pixel_out,
  output logic                                   out_frame_last
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic                      accept, take, spread_mode, stage_free;
  logic [AW-1:0]             rd_idx, wr_addr;
  bm3_pkg::bm3_item_t        item;
  logic [bm3_pkg::PIX_W-1:0] rd_top, rd_mid, wr_upper, wr_middle;
  logic                      wr_en;

  assign in_ready = stage_free;
  assign accept   = in_valid && in_ready;

  bm3_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .accept      (accept),
    .pixel_in    (in_pixel_in),
    .flush       (in_flush),
    .take        (take),
    .rd_idx      (rd_idx),
    .item        (item),
    .spread_mode (spread_mode)
  );

  bm3_line_buf #(.DEPTH(MAX_WIDTH)) u_line_buf (
    .clk       (clk),
    .rd_en     (take),
    .rd_addr   (rd_idx),
    .rd_top    (rd_top),
    .rd_mid    (rd_mid),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_upper  (wr_upper),
    .wr_middle (wr_middle)
  );

  bm3_window #(.AW(AW)) u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take),
    .item           (item),
    .idx            (rd_idx),
    .spread_mode    (spread_mode),
    .top            (rd_top),
    .mid            (rd_mid),
    .stage_free     (stage_free),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_upper       (wr_upper),
    .wr_middle      (wr_middle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_frame_last (out_frame_last)
  );

endmodule
`default_nettype wire

/* src/bm3_checker.sv */
// Port-level checks for binary_morphology_3x3_unit, attached by bind.
// Depends on bm3_pkg.
`default_nettype none
module bm3_port_sva (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [bm3_pkg::PIX_W-1:0]     out_pixel_out,
  input wire logic                          out_frame_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_out) &&
                                $stable(out_frame_last))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_frame_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_frame_last |=> !out_valid)
    else $error("result directly after frame end");

  a_stall_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without result backpressure");

endmodule

bind binary_morphology_3x3_unit bm3_port_sva u_bm3_port_sva (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_pixel_out  (out_pixel_out),
  .out_frame_last (out_frame_last)
);
`default_nettype wire

/* tb/bm3_checker.sv */
`timescale 1ns / 1ps
// Result checker for binary_morphology_3x3_unit: follows config writes and input transfers,
// predicts each filtered pixel and compares it with the result channel. Depends on bm3_pkg.
module bm3_checker #(
  parameter int MAX_WIDTH = bm3_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [bm3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bm3_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [bm3_pkg::PIX_W-1:0]       in_pixel_in,
  input  logic                            in_flush,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [bm3_pkg::PIX_W-1:0]       out_pixel_out,
  input  logic                            out_frame_last,
  output int unsigned                     mismatch_count,
  output int unsigned                     results_pending
);

  typedef struct packed {
    logic [bm3_pkg::PIX_W-1:0] pix;
    logic                      frame_last;
  } filtered_t;

  filtered_t filtered_q[$];
  filtered_t want;
  int unsigned result_idx;

  logic                             spread_white;
  logic [bm3_pkg::WIDTH_REG_W-1:0]  width_reg;
  logic [bm3_pkg::HEIGHT_REG_W-1:0] height_reg;

  bit [bm3_pkg::PIX_W-1:0] upper_row [MAX_WIDTH];
  bit [bm3_pkg::PIX_W-1:0] middle_row [MAX_WIDTH];
  bit [bm3_pkg::PIX_W-1:0] window [3][3];
  int unsigned             col_pos;
  int unsigned             row_pos;
  int unsigned             drain_left;

  task automatic report_mismatch(input string msg);
    $display("result %0d: %s", result_idx, msg);
    mismatch_count++;
  endtask

  task automatic clear_filter();
    spread_white = 1'b0;
    width_reg    = bm3_pkg::WIDTH_RST;
    height_reg   = bm3_pkg::HEIGHT_RST;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        window[r][c] = '0;
      end
    end
    col_pos    = 0;
    row_pos    = 0;
    drain_left = 0;
  endtask

  task automatic filter_step(input logic [bm3_pkg::PIX_W-1:0] pix_in, input logic flush);
    int unsigned             w, h, ci, ri, idx, ro, co;
    logic                    draining, emit, frame_end, last_pix;
    bit [bm3_pkg::PIX_W-1:0] pix, top, mid, value, target;
    w = 32'(width_reg);
    if (w < bm3_pkg::MIN_DIM) w = bm3_pkg::MIN_DIM;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = 32'(height_reg);
    if (h < bm3_pkg::MIN_DIM) h = bm3_pkg::MIN_DIM;
    if (h > bm3_pkg::MAX_HEIGHT) h = bm3_pkg::MAX_HEIGHT;
    draining = (drain_left != 0);
    if (!draining && flush) return;
    pix = draining ? bm3_pkg::PIX_BLACK : pix_in;
    ci  = col_pos;
    ri  = row_pos;

    idx = (ci < MAX_WIDTH) ? ci : 0;
    top = upper_row[idx];
    mid = middle_row[idx];
    upper_row[idx]  = mid;
    middle_row[idx] = pix;
    for (int r = 0; r < 3; r++) begin
      window[r][0] = window[r][1];
      window[r][1] = window[r][2];
    end
    window[0][2] = top;
    window[1][2] = mid;
    window[2][2] = pix;

    // center of the window trails the input by one row and one pixel
    emit  = (ri >= 2) || (ri == 1 && ci >= 1);
    value = window[1][1];
    if (emit) begin
      if (ci >= 1) begin
        ro = ri - 1;
        co = ci - 1;
      end else begin
        ro = ri - 2;
        co = w - 1;
      end
      if (ro >= 1 && ro + 2 <= h && co >= 1 && co + 2 <= w) begin
        target = spread_white ? bm3_pkg::PIX_WHITE : bm3_pkg::PIX_BLACK;
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            if (window[r][c] == target) value = target;
          end
        end
      end
    end

    last_pix = !draining && (ri + 1 >= h) && (ci + 1 >= w);
    if (ci + 1 >= w) begin
      col_pos = 0;
      row_pos = ri + 1;
    end else begin
      col_pos = ci + 1;
    end
    frame_end = 1'b0;
    if (draining) begin
      drain_left--;
      if (drain_left == 0) begin
        frame_end = 1'b1;
        col_pos   = 0;
        row_pos   = 0;
      end
    end
    if (last_pix) drain_left = w + 1;
    if (emit) filtered_q.push_back('{pix: value, frame_last: frame_end});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_filter();
      filtered_q.delete();
      mismatch_count = 0;
      result_idx     = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          report_mismatch($sformatf("transfer with nothing expected, pixel_out %0d",
                                    out_pixel_out));
        end else begin
          want = filtered_q.pop_front();
          if (out_pixel_out !== want.pix) begin
            report_mismatch($sformatf("pixel_out %0d, expected %0d", out_pixel_out, want.pix));
          end
          if (out_frame_last !== want.frame_last) begin
            report_mismatch($sformatf("frame_last %0b, expected %0b", out_frame_last,
                                      want.frame_last));
          end
        end
        result_idx++;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          bm3_pkg::REG_SPREAD_MODE:  spread_white = cfg_wdata[0];
          bm3_pkg::REG_IMAGE_WIDTH:  width_reg    = cfg_wdata[bm3_pkg::WIDTH_REG_W-1:0];
          bm3_pkg::REG_IMAGE_HEIGHT: height_reg   = cfg_wdata[bm3_pkg::HEIGHT_REG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) filter_step(in_pixel_in, in_flush);
    end
    results_pending <= filtered_q.size();
  end

endmodule

/* tb/binary_morphology_3x3_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench top for binary_morphology_3x3_unit: drives frames, drain transfers and config
// writes under several idle/stall mixes. Depends on bm3_pkg and bm3_checker.
module binary_morphology_3x3_unit_tb;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_wr_en;
  logic [bm3_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bm3_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_ready;
  logic [bm3_pkg::PIX_W-1:0]      in_pixel_in;
  logic                           in_flush;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [bm3_pkg::PIX_W-1:0]      out_pixel_out;
  logic                           out_frame_last;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned fail_count;
  int unsigned pending;

  binary_morphology_3x3_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_in    (in_pixel_in),
    .in_flush       (in_flush),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_frame_last (out_frame_last)
  );

  bm3_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel_in     (in_pixel_in),
    .in_flush        (in_flush),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_out   (out_pixel_out),
    .out_frame_last  (out_frame_last),
    .mismatch_count  (fail_count),
    .results_pending (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [bm3_pkg::PIX_W-1:0] pick_pixel(input int unsigned dens);
    if ($urandom_range(99) < dens) begin
      return $urandom_range(1) ? bm3_pkg::PIX_WHITE : bm3_pkg::PIX_BLACK;
    end
    return bm3_pkg::PIX_W'($urandom_range(255));
  endfunction

  task automatic send_item(input logic [bm3_pkg::PIX_W-1:0] pix, input logic flush);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= pix;
    in_flush    <= flush;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid, wait for every expected result, then let the pipe go quiet
  task automatic settle(input int tail);
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_config(input logic white,
                              input logic [bm3_pkg::CFG_DATA_W-1:0] w_val,
                              input logic [bm3_pkg::CFG_DATA_W-1:0] h_val);
    settle(6);
    cfg_wr_en <= 1'b1;
    cfg_index <= bm3_pkg::REG_SPREAD_MODE;
    cfg_wdata <= bm3_pkg::CFG_DATA_W'(white);
    @(posedge clk);
    cfg_index <= bm3_pkg::REG_IMAGE_WIDTH;
    cfg_wdata <= w_val;
    @(posedge clk);
    cfg_index <= bm3_pkg::REG_IMAGE_HEIGHT;
    cfg_wdata <= h_val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_frame(input int unsigned w, input int unsigned h,
                            input int unsigned dens, input int unsigned noise);
    for (int unsigned n = 0; n < w * h; n++) begin
      if ($urandom_range(99) < noise) begin
        send_item(bm3_pkg::PIX_W'($urandom_range(255)), 1'b1);
      end
      send_item(pick_pixel(dens), 1'b0);
    end
    for (int unsigned n = 0; n <= w; n++) begin
      send_item(bm3_pkg::PIX_W'($urandom_range(255)), $urandom_range(99) >= noise);
    end
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned quota);
    int unsigned                    sent;
    int unsigned                    w_eff, h_eff;
    logic [bm3_pkg::CFG_DATA_W-1:0] w_val, h_val;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < quota) begin
      w_eff = $urandom_range(3, 10);
      h_eff = $urandom_range(3, 8);
      w_val = bm3_pkg::CFG_DATA_W'(w_eff);
      h_val = bm3_pkg::CFG_DATA_W'(h_eff);
      if ($urandom_range(9) == 0) begin
        w_eff = bm3_pkg::MIN_DIM;
        w_val = bm3_pkg::CFG_DATA_W'($urandom_range(2));
      end
      if ($urandom_range(9) == 0) begin
        h_eff = bm3_pkg::MIN_DIM;
        h_val = bm3_pkg::CFG_DATA_W'($urandom_range(2));
      end
      write_config(1'($urandom_range(1)), w_val, h_val);
      send_frame(w_eff, h_eff, $urandom_range(30), 5);
      sent += w_eff * h_eff + w_eff + 1;
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = bm3_pkg::REG_SPREAD_MODE;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_pixel_in = '0;
    in_flush    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // width 1 and height 2 clamp to a 3x3 frame
    write_config(1'b0, bm3_pkg::CFG_DATA_W'(1), bm3_pkg::CFG_DATA_W'(2));
    send_item(8'h5A, 1'b1);
    send_item(bm3_pkg::PIX_BLACK, 1'b0);
    send_item(bm3_pkg::PIX_WHITE, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hFE, 1'b0);
    settle(0);
    send_item(8'h7F, 1'b0);
    send_item(8'h33, 1'b1);
    send_item(bm3_pkg::PIX_WHITE, 1'b0);
    send_item(bm3_pkg::PIX_BLACK, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'hC3, 1'b0);
    repeat (3) send_item(8'h00, 1'b1);

    run_phase(0, 0, 290);
    run_phase(79, 0, 290);
    run_phase(0, 79, 290);
    run_phase(29, 29, 290);

    settle(8);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
src/bm3_pkg.sv
src/bm3_line_buf.sv
src/bm3_ctrl.sv
src/bm3_window.sv
src/binary_morphology_3x3_unit.sv
src/bm3_checker.sv
tb/bm3_checker.sv
tb/binary_morphology_3x3_unit_tb.sv
